### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/lsbd_pkg.sv
// ----------------------------------------------------------------------------
// lsbd_pkg
// Types and constants of the light-sensor backlight dimmer.
// ----------------------------------------------------------------------------
`default_nettype none

package lsbd_pkg;

	localparam int SENSOR_BITS_DEFAULT = 12;

	// register reset values
	localparam int BRIGHT_RESET = 100;
	localparam int DARK_RESET   = 1024;
	localparam logic [7:0] STEPS_RESET  = 8'd10;
	localparam logic [7:0] DBAND_RESET  = 8'd2;
	localparam logic [7:0] LOW_RESET    = 8'd32;
	localparam logic [7:0] HIGH_RESET   = 8'd128;
	localparam logic [6:0] SLEW_RESET   = 7'd10;

	// drive level after reset
	localparam logic [7:0] LEVEL_RESET  = 8'd128;

	// slew is a percentage of the remaining gap
	localparam int PCT_DIV = 100;

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BRIGHT = 3'd0,
		CFG_DARK   = 3'd1,
		CFG_STEPS  = 3'd2,
		CFG_DBAND  = 3'd3,
		CFG_LOW    = 3'd4,
		CFG_HIGH   = 3'd5,
		CFG_SLEW   = 3'd6
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_STEP_GO,
		S_STEP_WAIT,
		S_LVL_GO,
		S_LVL_WAIT,
		S_SLEW_GO,
		S_SLEW_WAIT,
		S_OUT
	} state_t;

endpackage

`default_nettype wire

### rtl/core/lsbd_div.sv
// ----------------------------------------------------------------------------
// lsbd_div
// Restoring radix-2 divider, one quotient bit per cycle, shared by all
// three divisions of an update.
// ----------------------------------------------------------------------------
`default_nettype none

module lsbd_div #(
	parameter int NUM_W = 20,
	parameter int DEN_W = 12
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  done,
	output logic      [NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	// shift the next numerator bit into the partial remainder
	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

### rtl/core/light_sensor_backlight_dimmer_core.sv
// ----------------------------------------------------------------------------
// light_sensor_backlight_dimmer_core
// Maps a light-sensor reading to a quantized backlight target and slews the
// drive level toward it, one update per input word.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake          payload
//  s_*       in         tvalid / tready    tdata: raw_level
//  m_*       out        tvalid / tready    tdata: drive_level, level_changed,
//                                                 accepted_step, target_level
//  wr_*      in         wr_en (no wait)    wr_index, wr_data
//
//  A result word is loaded once its input word is accepted and the three
//  passes through the shared one-bit-per-cycle divider are done. Each pass
//  starts the divider, shifts out SENSOR_BITS+8 quotient bits and ends on
//  the divider's done strobe. s_tready is high only in the idle state, so
//  a new word is taken only once the previous one has left the sequencer;
//  a finished result sits in the output register and a new word
//  may be taken while it waits. A stalled m_tready holds the next result
//  in the sequencer until the output register frees. arst_n restores the
//  register reset values and clears the held step.
// ----------------------------------------------------------------------------
`default_nettype none

module light_sensor_backlight_dimmer_core
	import lsbd_pkg::*;
#(
	parameter int SENSOR_BITS = SENSOR_BITS_DEFAULT
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// bits from 0: raw_level [SENSOR_BITS-1:0], zero fill
	input  wire logic [((SENSOR_BITS+7)/8)*8-1:0]  s_tdata,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// bits from 0: drive_level [7:0], level_changed [8], accepted_step [16:9],
	// target_level [24:17], zero fill [31:25]
	output logic      [31:0]                       m_tdata,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	input  wire logic                              wr_en,
	input  wire logic [CFG_IDX_W-1:0]              wr_index,
	input  wire logic [((SENSOR_BITS > 8) ? SENSOR_BITS : 8)-1:0] wr_data
);

	localparam int SB = SENSOR_BITS;
	localparam int DW = SB + 8;

	// ---------------------------------------------------------------- config
	logic [SB-1:0] bright_q;
	logic [SB-1:0] dark_q;
	logic [7:0]    steps_q;
	logic [7:0]    dband_q;
	logic [7:0]    low_q;
	logic [7:0]    high_q;
	logic [6:0]    pct_q;

	// ----------------------------------------------------------------- state
	state_t        state_q;
	state_t        state_d;
	logic [SB-1:0] raw_q;
	logic [7:0]    step_q;
	logic          outside_q;
	logic [7:0]    held_step_q;
	logic [7:0]    held_level_q;
	logic          held_valid_q;
	logic [7:0]    cur_q;
	logic [7:0]    next_q;

	// output register
	logic          out_valid_q;
	logic [7:0]    drive_out_q;
	logic          chg_out_q;
	logic [7:0]    step_out_q;
	logic [7:0]    tgt_out_q;

	// --------------------------------------------------- derived from config
	logic [SB-1:0] lo;
	logic [SB-1:0] hi;
	logic [7:0]    n_steps;
	logic [7:0]    nm1;
	logic [7:0]    dz;
	logic [7:0]    lvl_a;
	logic [7:0]    lvl_b;
	logic [7:0]    mn;
	logic [7:0]    mx;

	// sort the bounds; lo is the smaller of bright and dark
	assign lo      = (bright_q < dark_q) ? bright_q : dark_q;
	assign hi      = (bright_q < dark_q) ? dark_q : bright_q;
	assign n_steps = (steps_q < 8'd2) ? 8'd2 : steps_q;
	assign nm1     = n_steps - 8'd1;
	// deadband never wider than the step range
	assign dz      = (dband_q > nm1) ? nm1 : dband_q;
	// swap the level ends if needed, then lift zero to one
	assign lvl_a   = (low_q < high_q) ? low_q : high_q;
	assign lvl_b   = (low_q < high_q) ? high_q : low_q;
	assign mn      = (lvl_a == 8'd0) ? 8'd1 : lvl_a;
	assign mx      = (lvl_b == 8'd0) ? 8'd1 : lvl_b;

	// -------------------------------------------------------- shared divider
	logic          div_start;
	logic [DW-1:0] div_num;
	logic [SB-1:0] div_den;
	logic          div_done;
	logic [DW-1:0] div_quo;

	logic [SB-1:0] span;
	logic [7:0]    lvl_span;
	logic [15:0]   lvl_prod;
	logic [7:0]    gap;
	logic [14:0]   slew_prod;

	// numerators; a reading outside the bounds gives a wrapped or oversized
	// span whose quotient is dropped later
	assign span      = hi - raw_q;
	assign lvl_span  = mx - mn;
	assign lvl_prod  = {8'd0, lvl_span} * {8'd0, step_q};
	assign gap       = (held_level_q > cur_q) ? (held_level_q - cur_q)
	                                          : (cur_q - held_level_q);
	assign slew_prod = {7'd0, gap} * {8'd0, pct_q};

	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		case (state_q)
			S_STEP_GO: begin
				div_start = 1'b1;
				div_num   = DW'(span) * DW'(nm1);
				div_den   = hi - lo;
			end
			S_LVL_GO: begin
				div_start = 1'b1;
				div_num   = DW'(lvl_prod);
				div_den   = SB'(nm1);
			end
			S_SLEW_GO: begin
				div_start = 1'b1;
				div_num   = DW'(slew_prod);
				div_den   = SB'(PCT_DIV);
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	lsbd_div #(
		.NUM_W (DW),
		.DEN_W (SB)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// ------------------------------------------------------ step and target
	logic [7:0] step_sel;
	logic       in_outside;
	logic [7:0] tgt_lvl;
	logic [7:0] step_diff;
	logic       take_new;

	assign in_outside = (raw_q <= lo) || (raw_q >= hi);

	always_comb begin
		if (lo == hi || raw_q <= lo) begin
			step_sel = nm1;
		end else if (raw_q >= hi) begin
			step_sel = 8'd0;
		end else begin
			step_sel = div_quo[7:0];
		end
	end

	assign tgt_lvl   = (mx <= mn) ? mn : (mn + div_quo[7:0]);
	assign step_diff = (step_q > held_step_q) ? (step_q - held_step_q)
	                                          : (held_step_q - step_q);
	// accept the new step when nothing is held, or when it differs from the held
	// step and the reading is out of range or the move clears the deadband
	assign take_new  = !held_valid_q
	                || ((step_q != held_step_q) && (outside_q || step_diff >= dz));

	// ------------------------------------------------------------------ slew
	logic [8:0] mv;
	logic [9:0] up_sum;
	logic [7:0] dn_gap;
	logic [7:0] slew_lvl;
	logic [7:0] next_lvl;

	// at least one level per update
	assign mv     = (div_quo[8:0] == 9'd0) ? 9'd1 : div_quo[8:0];
	assign up_sum = {2'd0, cur_q} + {1'b0, mv};
	assign dn_gap = cur_q - held_level_q;

	always_comb begin
		if (cur_q < held_level_q) begin
			slew_lvl = (up_sum < {2'd0, held_level_q}) ? up_sum[7:0] : held_level_q;
		end else if (cur_q > held_level_q) begin
			slew_lvl = ({1'b0, dn_gap} > mv) ? (cur_q - mv[7:0]) : held_level_q;
		end else begin
			slew_lvl = cur_q;
		end
	end

	assign next_lvl = (slew_lvl == 8'd0) ? 8'd1 : slew_lvl;

	// ------------------------------------------------------------- sequencer
	logic out_free;

	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = S_STEP_GO;
				end
			end
			S_STEP_GO:   state_d = S_STEP_WAIT;
			S_STEP_WAIT: if (div_done) state_d = S_LVL_GO;
			S_LVL_GO:    state_d = S_LVL_WAIT;
			S_LVL_WAIT:  if (div_done) state_d = S_SLEW_GO;
			S_SLEW_GO:   state_d = S_SLEW_WAIT;
			S_SLEW_WAIT: if (div_done) state_d = S_OUT;
			S_OUT:       if (out_free) state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	// -------------------------------------------------- config and held state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_q     <= SB'(BRIGHT_RESET);
			dark_q       <= SB'(DARK_RESET);
			steps_q      <= STEPS_RESET;
			dband_q      <= DBAND_RESET;
			low_q        <= LOW_RESET;
			high_q       <= HIGH_RESET;
			pct_q        <= SLEW_RESET;
			held_valid_q <= 1'b0;
			held_step_q  <= 8'd0;
			held_level_q <= 8'd0;
			cur_q        <= LEVEL_RESET;
			out_valid_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				// any write to a known register drops the held step
				case (cfg_idx_t'(wr_index))
					CFG_BRIGHT: begin
						bright_q     <= wr_data[SB-1:0];
						held_valid_q <= 1'b0;
					end
					CFG_DARK: begin
						dark_q       <= wr_data[SB-1:0];
						held_valid_q <= 1'b0;
					end
					CFG_STEPS: begin
						steps_q      <= wr_data[7:0];
						held_valid_q <= 1'b0;
					end
					CFG_DBAND: begin
						dband_q      <= wr_data[7:0];
						held_valid_q <= 1'b0;
					end
					CFG_LOW: begin
						low_q        <= wr_data[7:0];
						held_valid_q <= 1'b0;
					end
					CFG_HIGH: begin
						high_q       <= wr_data[7:0];
						held_valid_q <= 1'b0;
					end
					CFG_SLEW: begin
						pct_q        <= wr_data[6:0];
						held_valid_q <= 1'b0;
					end
					default: begin
						// unmapped index: ignore
					end
				endcase
			end

			if (state_q == S_LVL_WAIT && div_done && take_new) begin
				held_step_q  <= step_q;
				held_level_q <= tgt_lvl;
				held_valid_q <= 1'b1;
			end

			if (state_q == S_OUT && out_free) begin
				cur_q       <= next_q;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// -------------------------------------------------------------- payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_tvalid) begin
			raw_q <= s_tdata[SB-1:0];
		end
		if (state_q == S_STEP_WAIT && div_done) begin
			step_q    <= step_sel;
			outside_q <= in_outside;
		end
		if (state_q == S_SLEW_WAIT && div_done) begin
			next_q <= next_lvl;
		end
		if (state_q == S_OUT && out_free) begin
			drive_out_q <= next_q;
			chg_out_q   <= (next_q != cur_q);
			step_out_q  <= held_step_q;
			tgt_out_q   <= held_level_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, tgt_out_q, step_out_q, chg_out_q, drive_out_q};

endmodule

`default_nettype wire

### rtl/core/lsbd_chk.sv
// ----------------------------------------------------------------------------
// lsbd_chk
// Port-level checks of the dimmer core, bound into the core module.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lsbd_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata
);

	// a stalled result word stays offered
	`ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result word dropped while stalled")

	// one word in flight: input closes right after an acceptance
	`ASSERT_NEXT(a_one_busy, s_tvalid && s_tready, !s_tready, "input open during an update")

	// drive level never reaches zero
	`ASSERT_IMPLIES(a_drive_nz, m_tvalid, m_tdata[7:0] != 8'd0, "drive level zero")

	// target level never reaches zero
	`ASSERT_IMPLIES(a_tgt_nz, m_tvalid, m_tdata[24:17] != 8'd0, "target level zero")

endmodule

bind light_sensor_backlight_dimmer_core lsbd_chk u_lsbd_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

### verif/light_sensor_backlight_dimmer_core_tb.sv
// ----------------------------------------------------------------------------
// light_sensor_backlight_dimmer_core_tb
// Self-checking bench for the backlight dimmer core. Sensor readings are
// streamed in under random idling and one long output stall. A bit-exact
// model of the step, target and slew arithmetic predicts every result word,
// and the bench compares those predictions with the words that come out.
// ----------------------------------------------------------------------------
module light_sensor_backlight_dimmer_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lsbd_pkg::*;

	localparam int RAW_BITS = 12;
	localparam int RAW_MAX  = (1 << RAW_BITS) - 1;
	// wr_index code that names no register: a write to it must not clear the held step
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

	typedef struct {
		logic [7:0] drive;
		logic       changed;
		logic [7:0] step;
		logic [7:0] target;
	} update_t;

	// ------------------------------------------------------------------------
	// Predictor and checker
	// ------------------------------------------------------------------------
	class dimmer_scoreboard;
		int unsigned bright_rd, dark_rd, steps_reg, dband_reg, low_reg, high_reg, slew_reg;
		int unsigned drive_now, held_idx, held_lvl;
		bit          held_ok;
		int          errors;
		int          words_done;
		update_t     expected_words[$];

		function new();
			bright_rd  = BRIGHT_RESET;
			dark_rd    = DARK_RESET;
			steps_reg  = STEPS_RESET;
			dband_reg  = DBAND_RESET;
			low_reg    = LOW_RESET;
			high_reg   = HIGH_RESET;
			slew_reg   = SLEW_RESET;
			drive_now  = LEVEL_RESET;
			held_idx   = 0;
			held_lvl   = 0;
			held_ok    = 1'b0;
			errors     = 0;
			words_done = 0;
		endfunction

		function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
			return (v < lo) ? lo : ((v > hi) ? hi : v);
		endfunction

		// Registers keep only their own width; any real write drops the held step.
		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [11:0] val);
			case (idx)
				CFG_BRIGHT: bright_rd = val;
				CFG_DARK:   dark_rd   = val;
				CFG_STEPS:  steps_reg = val[7:0];
				CFG_DBAND:  dband_reg = val[7:0];
				CFG_LOW:    low_reg   = val[7:0];
				CFG_HIGH:   high_reg  = val[7:0];
				CFG_SLEW:   slew_reg  = val[6:0];
				default:    return;
			endcase
			held_ok = 1'b0;
		endfunction

		// Work out the update that an accepted reading causes and queue it.
		function void note_reading(logic [RAW_BITS-1:0] raw_in);
			int unsigned raw, lo, hi, n, s, tgt, mn, mx, dz, diff, gap, mv, prev, nxt;
			bit          outside;
			update_t     upd;
			raw = raw_in;
			lo  = (bright_rd < dark_rd) ? bright_rd : dark_rd;
			hi  = (bright_rd < dark_rd) ? dark_rd : bright_rd;
			n   = clamp(steps_reg, 2, 255);
			if (lo == hi || raw <= lo)
				s = n - 1;
			else if (raw >= hi)
				s = 0;
			else
				s = ((hi - raw) * (n - 1)) / (hi - lo);
			mn = clamp((low_reg < high_reg) ? low_reg : high_reg, 1, 255);
			mx = clamp((low_reg < high_reg) ? high_reg : low_reg, 1, 255);
			tgt = (mx <= mn) ? mn : mn + ((mx - mn) * s) / (n - 1);
			dz = (dband_reg > n - 1) ? n - 1 : dband_reg;
			outside = (raw <= lo) || (raw >= hi);

			if (!held_ok) begin
				held_idx = s;
				held_lvl = tgt;
				held_ok  = 1'b1;
			end else if (s != held_idx) begin
				diff = (s > held_idx) ? s - held_idx : held_idx - s;
				if (outside || diff >= dz) begin
					held_idx = s;
					held_lvl = tgt;
				end
			end

			prev = drive_now;
			nxt  = prev;
			gap  = (held_lvl > prev) ? held_lvl - prev : prev - held_lvl;
			mv   = (gap * slew_reg) / PCT_DIV;
			if (mv < 1)
				mv = 1;
			if (prev < held_lvl)
				nxt = (prev + mv < held_lvl) ? prev + mv : held_lvl;
			else if (prev > held_lvl)
				nxt = (prev - held_lvl > mv) ? prev - mv : held_lvl;
			nxt = clamp(nxt, 1, 255);
			drive_now = nxt;

			upd.drive   = nxt[7:0];
			upd.changed = (nxt != prev);
			upd.step    = held_idx[7:0];
			upd.target  = held_lvl[7:0];
			expected_words.push_back(upd);
		endfunction

		task report(string what, int unsigned got, int unsigned want);
			errors++;
			if (errors <= 40)
				$display("MISMATCH %s: got %0d, want %0d at %0t ns", what, got, want, $time);
		endtask

		// Compare one result word with the oldest pending update.
		task check_word(logic [31:0] word);
			update_t want;
			if (expected_words.size() == 0) begin
				report("word with no reading pending", word, 0);
				return;
			end
			want = expected_words.pop_front();
			words_done++;
			if (word[7:0] !== want.drive)
				report("drive_level", word[7:0], want.drive);
			if (word[8] !== want.changed)
				report("level_changed", word[8], want.changed);
			if (word[16:9] !== want.step)
				report("accepted_step", word[16:9], want.step);
			if (word[24:17] !== want.target)
				report("target_level", word[24:17], want.target);
		endtask
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset and block
	// ------------------------------------------------------------------------
	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	// bits from 0: raw_level [11:0], zero fill [15:12]
	logic [15:0] s_tdata  = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// bits from 0: drive_level [7:0], level_changed [8], accepted_step [16:9],
	// target_level [24:17], zero fill [31:25]
	logic [31:0] m_tdata;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic        wr_en    = 1'b0;
	logic [CFG_IDX_W-1:0] wr_index = '0;
	logic [11:0] wr_data  = '0;

	dimmer_scoreboard sb = new();

	bit gaps_on   = 1'b1;   // random idling on both sides
	int hold_req  = 0;      // cycles the receiver is asked to stall
	int words_sent = 0;

	always #2 clk = ~clk;

	light_sensor_backlight_dimmer_core #(
		.SENSOR_BITS (RAW_BITS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// Watch both handshakes on the edge; all values seen here are pre-edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_reading(s_tdata[RAW_BITS-1:0]);
			if (m_tvalid && m_tready)
				sb.check_word(m_tdata);
		end
	end

	// Receiver: random back-pressure, or a long hold when asked. The hold is
	// counted here so the sender keeps offering words while the block backs up.
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req != 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= !(gaps_on && $urandom_range(99) < 20);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Driver tasks
	// ------------------------------------------------------------------------

	// Offer one reading; drop valid only for idle cycles so back-to-back
	// words keep valid high across the accepting edge.
	task send_word(input int unsigned raw);
		while (gaps_on && $urandom_range(99) < 20) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0, raw[RAW_BITS-1:0]};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		words_sent++;
	endtask

	// Stop offering and wait until every result is back and the core is idle.
	task settle(input int tail);
		s_tvalid <= 1'b0;
		while (sb.words_done != words_sent)
			@(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	// One register write; the caller lowers wr_en after its last write.
	task put_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val[11:0];
		@(posedge clk);
		sb.write_reg(idx, val[11:0]);
	endtask

	task program_regs(input int unsigned bright, dark, steps, dband, lo_lvl, hi_lvl, slew);
		put_reg(CFG_BRIGHT, bright);
		put_reg(CFG_DARK,   dark);
		put_reg(CFG_STEPS,  steps);
		put_reg(CFG_DBAND,  dband);
		put_reg(CFG_LOW,    lo_lvl);
		put_reg(CFG_HIGH,   hi_lvl);
		put_reg(CFG_SLEW,   slew);
		wr_en <= 1'b0;
	endtask

	// Mostly a value in the usual range, sometimes any 12-bit pattern so the
	// width masking and the use-time clamps get exercised.
	function automatic int unsigned pick_val(int unsigned lo, int unsigned hi);
		if ($urandom_range(7) == 0)
			return $urandom_range(RAW_MAX);
		return $urandom_range(lo, hi);
	endfunction

	task random_setup();
		int unsigned b, d, t, st;
		b = $urandom_range(0, 3000);
		case ($urandom_range(7))
			0:       d = b;                          // equal bounds
			1:       d = $urandom_range(RAW_MAX);
			default: d = b + $urandom_range(2, 1095);
		endcase
		if ($urandom_range(1)) begin
			t = b;
			b = d;
			d = t;
		end
		case ($urandom_range(7))
			0:       st = 255;
			1:       st = $urandom_range(1);         // below the minimum count
			default: st = pick_val(2, 24);
		endcase
		program_regs(b, d, st, pick_val(0, 6), pick_val(0, 255), pick_val(0, 255),
			pick_val(0, 100));
	endtask

	// Next random reading: mostly a walk from the previous one so the deadband
	// gets tested, plus spread over the range, anywhere, and the bound edges.
	function automatic int unsigned next_reading(int unsigned prev_raw);
		int lo, hi, v, delta;
		lo = (sb.bright_rd < sb.dark_rd) ? sb.bright_rd : sb.dark_rd;
		hi = (sb.bright_rd < sb.dark_rd) ? sb.dark_rd : sb.bright_rd;
		case ($urandom_range(9))
			0, 1, 2, 3: begin
				delta = $urandom_range(0, (hi - lo) / 16 + 3);
				v = $urandom_range(1) ? int'(prev_raw) + delta : int'(prev_raw) - delta;
			end
			4, 5, 6: v = $urandom_range(lo, hi);
			7:       v = $urandom_range(RAW_MAX);
			default: begin
				case ($urandom_range(5))
					0:       v = 0;
					1:       v = RAW_MAX;
					2:       v = lo;
					3:       v = hi;
					4:       v = lo + 1;
					default: v = hi - 1;
				endcase
			end
		endcase
		if (v < 0)
			v = 0;
		if (v > RAW_MAX)
			v = RAW_MAX;
		return v;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin
		int unsigned last_raw;
		last_raw = 512;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: bounds, just past them, mid range, and small moves
		// that the deadband should swallow.
		send_word(0);
		send_word(RAW_MAX);
		send_word(100);
		send_word(1024);
		send_word(99);
		send_word(1025);
		send_word(562);
		send_word(560);
		send_word(600);
		settle(16);

		// Bright above dark, step count below two, deadband past the top step,
		// low level above high with high at zero, slew of zero.
		program_regs(3000, 200, 0, 255, 200, 0, 0);
		send_word(RAW_MAX);
		send_word(0);
		send_word(1500);
		send_word(1600);
		settle(16);

		// Equal bounds, top step count, no deadband, empty level range, slew
		// past 100.
		program_regs(777, 777, 255, 0, 0, 0, 127);
		send_word(777);
		send_word(0);
		send_word(RAW_MAX);
		settle(16);

		// Full span with the widest deadband; a write to an unused index must
		// leave the held step in place.
		program_regs(0, RAW_MAX, 255, 254, 255, 1, 100);
		send_word(2048);
		send_word(2040);
		settle(16);
		put_reg(CFG_UNUSED, 12'hFFF);
		wr_en <= 1'b0;
		send_word(2030);
		send_word(0);
		send_word(RAW_MAX);

		// Random phases: phase 2 runs without idling, phase 5 opens with a
		// long output stall so the input side backs up.
		for (int ph = 0; ph < 8; ph++) begin
			settle(16);
			random_setup();
			gaps_on = (ph != 2);
			if (ph == 5)
				hold_req = 1500;
			for (int k = 0; k < 200; k++) begin
				// now and then rewrite one register mid-phase, unused index included
				if (k != 0 && k % 50 == 0 && $urandom_range(1)) begin
					settle(16);
					put_reg($urandom_range(7), pick_val(0, 255));
					wr_en <= 1'b0;
				end
				last_raw = next_reading(last_raw);
				send_word(last_raw);
			end
		end

		settle(80);
		if (sb.errors == 0 && sb.expected_words.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Watchdog far above the slowest correct run.
	initial begin
		#4_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

### light_sensor_backlight_dimmer_core.f
+incdir+rtl/core
rtl/core/lsbd_pkg.sv
rtl/core/lsbd_div.sv
rtl/core/light_sensor_backlight_dimmer_core.sv
rtl/core/lsbd_chk.sv
verif/light_sensor_backlight_dimmer_core_tb.sv
